FILE: rtl/core/tdb_pkg.sv
// Shared constants and types for the touch debounce trigger.
// Used by the top level and by its bound checker; depends on nothing.
`default_nettype none

package tdb_pkg;

    localparam int KEY_COUNT  = 12;
    localparam int TIME_BITS  = 32;
    localparam int STEP_W     = 10;
    localparam int THRESH_W   = 16;
    localparam int COUNT_W    = 17;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 3;

    localparam int S_FIELDS_W = KEY_COUNT + 1 + TIME_BITS;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + KEY_COUNT + 1 + 1;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_DATA_W - M_FIELDS_W;

    // Bit positions of the result word.
    localparam int M_FIRE_BIT    = 0;
    localparam int M_TOUCHED_BIT = KEY_COUNT + 1;
    localparam int M_ARMED_BIT   = KEY_COUNT + 2;

    localparam logic [STEP_W-1:0]   RST_POLL_STEP = STEP_W'(30);
    localparam logic [THRESH_W-1:0] RST_DETECT    = THRESH_W'(300);
    localparam logic [THRESH_W-1:0] RST_RELEASE   = THRESH_W'(300);
    localparam logic [THRESH_W-1:0] RST_COOLDOWN  = THRESH_W'(500);
    localparam logic [COUNT_W-1:0]  RST_REL_COUNT = COUNT_W'(300);
    localparam logic [COUNT_W-1:0]  COUNT_MAX     = {COUNT_W{1'b1}};

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_IDLE_MASK    = 3'd0,
        CFG_POLL_STEP    = 3'd1,
        CFG_DETECT_TIME  = 3'd2,
        CFG_RELEASE_TIME = 3'd3,
        CFG_COOLDOWN     = 3'd4
    } cfg_index_t;

endpackage

`default_nettype wire

FILE: rtl/core/touch_debounce_trigger.sv
// Debounced touch-key trigger with cooldown, top level.
// Depends on tdb_pkg for widths, reset values and register indexes.
//
// Each input word is one sensor poll: the key bitmap, a read-valid flag and
// a millisecond timestamp. Each accepted poll produces exactly one result
// word with the fire flag, the active keys, the touched flag and the armed
// flag after the poll. The configuration port writes one register per cycle
// when cfg_wr_en is high and is meant to be used while no poll is in flight.
// A poll is held in an input register, then the debounce and trigger logic
// updates the state and loads the result register, where the result shows
// as valid. One poll per cycle is sustained while the receiver accepts
// results. When the receiver stalls, the result register holds its word
// and the input register holds one more poll; s_tready drops only when both
// are full. Synchronous reset restores the register defaults, arms the
// block, clears the touch counter, presets the release counter to 300 and
// empties both registers.
`default_nettype none

module touch_debounce_trigger (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // Fields from bit 0: key bitmap, read_ok, now_ms, zero padding.
    input  wire logic [tdb_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // Fields from bit 0: fire, live key map, touched, armed_now, zero padding.
    output logic [tdb_pkg::M_DATA_W-1:0]          m_tdata,
    input  wire logic                             cfg_wr_en,
    input  wire logic [tdb_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [tdb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int KC = tdb_pkg::KEY_COUNT;
    localparam int TB = tdb_pkg::TIME_BITS;
    localparam int CW = tdb_pkg::COUNT_W;

    logic [KC-1:0]                  idle_mask_reg;
    logic [tdb_pkg::STEP_W-1:0]     poll_step_reg;
    logic [tdb_pkg::THRESH_W-1:0]   detect_time_reg;
    logic [tdb_pkg::THRESH_W-1:0]   release_time_reg;
    logic [tdb_pkg::THRESH_W-1:0]   cooldown_reg;

    logic          in_valid_reg;
    logic [KC-1:0] in_keys_reg;
    logic          in_ok_reg;
    logic [TB-1:0] in_now_reg;

    logic          armed_reg, armed_next;
    logic [CW-1:0] touch_cnt_reg, touch_cnt_next;
    logic [CW-1:0] rel_cnt_reg, rel_cnt_next;
    logic [KC-1:0] reported_reg, reported_next;
    logic [TB-1:0] last_fire_reg, last_fire_next;
    logic          has_fired_reg, has_fired_next;

    logic                              out_valid_reg;
    logic [tdb_pkg::M_FIELDS_W-1:0]    out_data_reg, out_data_next;

    logic          out_free;
    logic          advance;
    logic [KC-1:0] active;
    logic          touched;
    logic [CW:0]   touch_sum;
    logic [CW:0]   rel_sum;
    logic [CW-1:0] touch_sat;
    logic [CW-1:0] rel_sat;
    logic [TB-1:0] elapsed;
    logic          cool;
    logic          fresh;
    logic          fire;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_mask_reg    <= '0;
            poll_step_reg    <= tdb_pkg::RST_POLL_STEP;
            detect_time_reg  <= tdb_pkg::RST_DETECT;
            release_time_reg <= tdb_pkg::RST_RELEASE;
            cooldown_reg     <= tdb_pkg::RST_COOLDOWN;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                tdb_pkg::CFG_IDLE_MASK:    idle_mask_reg    <= cfg_wdata[KC-1:0];
                tdb_pkg::CFG_POLL_STEP:    poll_step_reg    <= cfg_wdata[tdb_pkg::STEP_W-1:0];
                tdb_pkg::CFG_DETECT_TIME:  detect_time_reg  <= cfg_wdata;
                tdb_pkg::CFG_RELEASE_TIME: release_time_reg <= cfg_wdata;
                tdb_pkg::CFG_COOLDOWN:     cooldown_reg     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_keys_reg <= s_tdata[KC-1:0];
            in_ok_reg   <= s_tdata[KC];
            in_now_reg  <= s_tdata[KC+TB:KC+1];
        end
    end

    assign active    = in_keys_reg & ~idle_mask_reg;
    assign touched   = |active;
    assign touch_sum = {1'b0, touch_cnt_reg} + (CW+1)'(poll_step_reg);
    assign rel_sum   = {1'b0, rel_cnt_reg} + (CW+1)'(poll_step_reg);
    assign touch_sat = touch_sum[CW] ? tdb_pkg::COUNT_MAX : touch_sum[CW-1:0];
    assign rel_sat   = rel_sum[CW] ? tdb_pkg::COUNT_MAX : rel_sum[CW-1:0];
    assign elapsed   = in_now_reg - last_fire_reg;
    assign cool      = !has_fired_reg || (elapsed >= TB'(cooldown_reg));
    assign fresh     = |(active & ~reported_reg);

    always_comb begin
        armed_next     = armed_reg;
        touch_cnt_next = touch_cnt_reg;
        rel_cnt_next   = rel_cnt_reg;
        reported_next  = reported_reg;
        last_fire_next = last_fire_reg;
        has_fired_next = has_fired_reg;
        fire           = 1'b0;
        if (in_ok_reg) begin
            if (touched) begin
                rel_cnt_next = '0;
                if (touch_cnt_reg < CW'(detect_time_reg)) begin
                    touch_cnt_next = touch_sat;
                end
            end else if (rel_cnt_reg < CW'(release_time_reg)) begin
                touch_cnt_next = '0;
                rel_cnt_next   = rel_sat;
                if (rel_sat >= CW'(release_time_reg)) begin
                    armed_next    = 1'b1;
                    reported_next = '0;
                end
            end else begin
                touch_cnt_next = '0;
            end
            if (touched && armed_reg && (touch_cnt_next >= CW'(detect_time_reg))
                    && cool && fresh) begin
                fire           = 1'b1;
                armed_next     = 1'b0;
                reported_next  = reported_reg | active;
                last_fire_next = in_now_reg;
                has_fired_next = 1'b1;
            end
            out_data_next = {armed_next, touched, active, fire};
        end else begin
            out_data_next = {armed_reg, 1'b0, {KC{1'b0}}, 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg     <= 1'b1;
            touch_cnt_reg <= '0;
            rel_cnt_reg   <= tdb_pkg::RST_REL_COUNT;
            reported_reg  <= '0;
            last_fire_reg <= '0;
            has_fired_reg <= 1'b0;
        end else if (advance) begin
            armed_reg     <= armed_next;
            touch_cnt_reg <= touch_cnt_next;
            rel_cnt_reg   <= rel_cnt_next;
            reported_reg  <= reported_next;
            last_fire_reg <= last_fire_next;
            has_fired_reg <= has_fired_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{tdb_pkg::M_PAD_W{1'b0}}, out_data_reg};

endmodule

`default_nettype wire

FILE: rtl/core/tdb_checker.sv
// Port-level checker for touch_debounce_trigger, bound to the top level.
// Depends on tdb_pkg for the result word layout.
`default_nettype none

module tdb_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [tdb_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int KC = tdb_pkg::KEY_COUNT;

    a_fire_needs_touch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[tdb_pkg::M_FIRE_BIT] |-> m_tdata[tdb_pkg::M_TOUCHED_BIT])
        else $error("fire reported without a touch");

    a_fire_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[tdb_pkg::M_FIRE_BIT] |-> !m_tdata[tdb_pkg::M_ARMED_BIT])
        else $error("block still armed after firing");

    a_touched_matches_keys: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[tdb_pkg::M_TOUCHED_BIT] == (m_tdata[KC:1] != '0)))
        else $error("touched flag disagrees with active keys");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind touch_debounce_trigger tdb_checker u_tdb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: dv/touch_debounce_trigger_tb.sv
// Self-checking testbench for touch_debounce_trigger: a scoreboard class tracks the
// debounce, arming and cooldown state, and plain tasks drive polls, stalls and register writes.
// Depends on tdb_pkg and the touch_debounce_trigger top level.
`default_nettype none

module touch_debounce_trigger_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [tdb_pkg::TIME_BITS-1:0] now_ms;
        logic                          read_ok;
        logic [tdb_pkg::KEY_COUNT-1:0] keys;
    } poll_t;

    typedef struct packed {
        logic                          armed;
        logic                          touched;
        logic [tdb_pkg::KEY_COUNT-1:0] keys;
        logic                          fire;
    } trigger_result_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [tdb_pkg::S_DATA_W-1:0]   s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [tdb_pkg::M_DATA_W-1:0]   m_tdata;
    logic                           cfg_wr_en;
    logic [tdb_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [tdb_pkg::CFG_DATA_W-1:0] cfg_wdata;

    logic                           no_idle = 1'b0;
    logic                           hold_off = 1'b0;
    logic [tdb_pkg::TIME_BITS-1:0]  clock_ms;

    touch_debounce_trigger i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    class trigger_scoreboard;
        logic [tdb_pkg::KEY_COUNT-1:0] idle_mask;
        logic [tdb_pkg::STEP_W-1:0]    poll_step;
        logic [tdb_pkg::THRESH_W-1:0]  detect_t;
        logic [tdb_pkg::THRESH_W-1:0]  release_t;
        logic [tdb_pkg::THRESH_W-1:0]  cooldown;
        logic                          armed;
        logic                          has_fired;
        logic [tdb_pkg::COUNT_W-1:0]   touch_cnt;
        logic [tdb_pkg::COUNT_W-1:0]   rel_cnt;
        logic [tdb_pkg::KEY_COUNT-1:0] reported;
        logic [tdb_pkg::TIME_BITS-1:0] last_fire;
        trigger_result_t               expected_results[$];
        int                            errors;

        function new();
            idle_mask = '0;
            poll_step = 30;
            detect_t = 300;
            release_t = 300;
            cooldown = 500;
            armed = 1'b1;
            has_fired = 1'b0;
            touch_cnt = '0;
            rel_cnt = 300;
            reported = '0;
            last_fire = '0;
            errors = 0;
        endfunction

        task flag_error(input string msg);
            $display("ERROR at %0t ns: %s", $realtime, msg);
            errors++;
        endtask

        function logic [tdb_pkg::COUNT_W-1:0] bump(input logic [tdb_pkg::COUNT_W-1:0] cnt);
            logic [tdb_pkg::COUNT_W:0] sum;
            sum = cnt + poll_step;
            return (sum > {tdb_pkg::COUNT_W{1'b1}}) ? {tdb_pkg::COUNT_W{1'b1}}
                                                    : sum[tdb_pkg::COUNT_W-1:0];
        endfunction

        function void write_reg(input logic [tdb_pkg::CFG_ADDR_W-1:0] addr,
                                input logic [tdb_pkg::CFG_DATA_W-1:0] data);
            case (addr)
                tdb_pkg::CFG_IDLE_MASK:    idle_mask = data[tdb_pkg::KEY_COUNT-1:0];
                tdb_pkg::CFG_POLL_STEP:    poll_step = data[tdb_pkg::STEP_W-1:0];
                tdb_pkg::CFG_DETECT_TIME:  detect_t = data[tdb_pkg::THRESH_W-1:0];
                tdb_pkg::CFG_RELEASE_TIME: release_t = data[tdb_pkg::THRESH_W-1:0];
                tdb_pkg::CFG_COOLDOWN:     cooldown = data[tdb_pkg::THRESH_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_poll(input poll_t p);
            trigger_result_t               r;
            logic [tdb_pkg::KEY_COUNT-1:0] act;
            logic [tdb_pkg::TIME_BITS-1:0] elapsed;
            logic                          cool;
            logic                          fresh;
            r = '0;
            if (!p.read_ok) begin
                r.armed = armed;
            end else begin
                act = p.keys & ~idle_mask;
                if (act != '0) begin
                    rel_cnt = '0;
                    if (touch_cnt < detect_t) touch_cnt = bump(touch_cnt);
                end else if (rel_cnt < release_t) begin
                    touch_cnt = '0;
                    rel_cnt = bump(rel_cnt);
                    if (rel_cnt >= release_t) begin
                        armed = 1'b1;
                        reported = '0;
                    end
                end else begin
                    touch_cnt = '0;
                end
                elapsed = p.now_ms - last_fire;
                cool = !has_fired || (elapsed >= cooldown);
                fresh = (act & ~reported) != '0;
                if (act != '0 && armed && touch_cnt >= detect_t && cool && fresh) begin
                    r.fire = 1'b1;
                    armed = 1'b0;
                    reported = reported | act;
                    last_fire = p.now_ms;
                    has_fired = 1'b1;
                end
                r.keys = act;
                r.touched = act != '0;
                r.armed = armed;
            end
            expected_results.push_back(r);
        endfunction

        task check_result(input logic [tdb_pkg::M_DATA_W-1:0] word);
            trigger_result_t got;
            trigger_result_t want;
            got = word[tdb_pkg::M_FIELDS_W-1:0];
            if (expected_results.size() == 0) begin
                flag_error($sformatf("result word %h arrived with none expected", word));
            end else begin
                want = expected_results.pop_front();
                if (got.fire !== want.fire)
                    flag_error($sformatf("fire %b, expected %b", got.fire, want.fire));
                if (got.keys !== want.keys)
                    flag_error($sformatf("live key map %h, expected %h", got.keys, want.keys));
                if (got.touched !== want.touched)
                    flag_error($sformatf("touched %b, expected %b", got.touched, want.touched));
                if (got.armed !== want.armed)
                    flag_error($sformatf("armed_now %b, expected %b", got.armed, want.armed));
                if (word[tdb_pkg::M_DATA_W-1:tdb_pkg::M_FIELDS_W] !== '0)
                    flag_error($sformatf("padding bits of word %h are not zero", word));
            end
        endtask
    endclass

    trigger_scoreboard sb;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("touch_debounce_trigger verification failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (s_tvalid && s_tready) sb.take_poll(s_tdata[tdb_pkg::S_FIELDS_W-1:0]);
            if (cfg_wr_en) sb.write_reg(cfg_addr, cfg_wdata);
        end
    end

    // Result side: random back-pressure, plus a long hold-off on request.
    initial begin
        int unsigned pause;
        m_tready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            pause = no_idle ? 0 : $urandom_range(0, 4);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (150) @(posedge aclk);
                hold_off = 1'b0;
            end else if (pause > 0) begin
                m_tready <= 1'b0;
                repeat (pause) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    task automatic send_poll(input logic [tdb_pkg::KEY_COUNT-1:0] keys, input logic ok,
                             input logic [tdb_pkg::TIME_BITS-1:0] now);
        poll_t p;
        int    gap;
        p.keys = keys;
        p.read_ok = ok;
        p.now_ms = now;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= tdb_pkg::S_DATA_W'(p);
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [tdb_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [tdb_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [tdb_pkg::CFG_DATA_W-1:0] mask_v, step_v,
                                  det_v, rel_v, cool_v);
        set_reg(tdb_pkg::CFG_IDLE_MASK, mask_v);
        set_reg(tdb_pkg::CFG_POLL_STEP, step_v);
        set_reg(tdb_pkg::CFG_DETECT_TIME, det_v);
        set_reg(tdb_pkg::CFG_RELEASE_TIME, rel_v);
        set_reg(tdb_pkg::CFG_COOLDOWN, cool_v);
        // An index past the register list must leave every setting alone.
        set_reg(tdb_pkg::CFG_ADDR_W'(tdb_pkg::CFG_COOLDOWN + 1 + $urandom_range(0, 2)),
                tdb_pkg::CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly touch-then-release episodes paced around the poll step, with some noise.
    task automatic run_phase(input int quota);
        int                            sent;
        int                            span_t;
        int                            span_r;
        int                            n;
        int                            k;
        int                            pace;
        int                            step_eff;
        logic [tdb_pkg::KEY_COUNT-1:0] keys;
        sent = 0;
        step_eff = (sb.poll_step == 0) ? 30 : int'(sb.poll_step);
        span_t = (sb.poll_step == 0) ? 4 : int'(sb.detect_t) / step_eff + 2;
        span_r = (sb.poll_step == 0) ? 4 : int'(sb.release_t) / step_eff + 2;
        if (span_t > 70) span_t = 70;
        if (span_r > 70) span_r = 70;
        while (sent < quota) begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 5);
                for (k = 0; k < n; k++) begin
                    send_poll(tdb_pkg::KEY_COUNT'($urandom_range(0, 4095)),
                              1'($urandom_range(0, 1)), $urandom);
                    sent++;
                end
            end else begin
                case ($urandom_range(0, 2))
                    0: pace = step_eff / 4;
                    1: pace = step_eff;
                    default: pace = 3 * step_eff;
                endcase
                keys = tdb_pkg::KEY_COUNT'($urandom_range(1, 4095));
                if ($urandom_range(0, 5) == 0) keys &= sb.idle_mask;
                n = $urandom_range(1, span_t);
                for (k = 0; k < n; k++) begin
                    if ($urandom_range(0, 3) == 0)
                        keys = tdb_pkg::KEY_COUNT'($urandom_range(1, 4095));
                    clock_ms += $urandom_range(0, 2 * pace);
                    if ($urandom_range(0, 9) == 0)
                        send_poll(tdb_pkg::KEY_COUNT'($urandom_range(0, 4095)), 1'b0,
                                  clock_ms);
                    else
                        send_poll(keys, 1'b1, clock_ms);
                    sent++;
                end
                n = $urandom_range(1, span_r);
                for (k = 0; k < n; k++) begin
                    clock_ms += $urandom_range(0, 2 * pace);
                    keys = ($urandom_range(0, 2) == 0) ?
                           tdb_pkg::KEY_COUNT'($urandom_range(0, 4095)) & sb.idle_mask : '0;
                    if ($urandom_range(0, 9) == 0)
                        send_poll(tdb_pkg::KEY_COUNT'($urandom_range(0, 4095)), 1'b0,
                                  clock_ms);
                    else
                        send_poll(keys, 1'b1, clock_ms);
                    sent++;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        int                             ph;
        int                             guard;
        logic [tdb_pkg::CFG_DATA_W-1:0] mask_v;
        logic [tdb_pkg::CFG_DATA_W-1:0] step_v;
        logic [tdb_pkg::CFG_DATA_W-1:0] det_v;
        logic [tdb_pkg::CFG_DATA_W-1:0] rel_v;
        logic [tdb_pkg::CFG_DATA_W-1:0] cool_v;
        sb = new();
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_wr_en <= 1'b0;
        cfg_addr <= tdb_pkg::CFG_IDLE_MASK;
        cfg_wdata <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: a failed read, a stable touch that fires, a disarmed touch,
        // a stable release that re-arms, then a new touch at the ends of the time range.
        send_poll(12'hFFF, 1'b0, 32'hFFFF_FFFF);
        for (int i = 0; i < 10; i++) send_poll(12'h001 << i, 1'b1, 30 * i);
        send_poll(12'hFFF, 1'b1, 330);
        for (int i = 1; i <= 10; i++) send_poll('0, 1'b1, 330 + 30 * i);
        send_poll(12'hFFF, 1'b1, 32'h0000_0000);
        send_poll(12'h800, 1'b1, 32'hFFFF_FFFF);
        clock_ms = 800;

        for (ph = 0; ph < 12; ph++) begin
            settle();
            case (ph)
                0: begin
                    mask_v = 0; step_v = 30; det_v = 300; rel_v = 300; cool_v = 500;
                end
                1: begin
                    mask_v = tdb_pkg::CFG_DATA_W'($urandom & $urandom & 12'hFFF);
                    step_v = 1000; det_v = 16'hFFFF; rel_v = 16'hFFFF; cool_v = 16'hFFFF;
                end
                2: begin
                    mask_v = 0; step_v = 1; det_v = 0; rel_v = 0; cool_v = 0;
                end
                3: begin
                    mask_v = 16'hFFFF; step_v = 16'hFFFF; det_v = 16'hFFFF;
                    rel_v = 16'hFFFF; cool_v = 16'hFFFF;
                end
                4: begin
                    mask_v = 0; step_v = 0; det_v = 90; rel_v = 90; cool_v = 100;
                end
                default: begin
                    mask_v = tdb_pkg::CFG_DATA_W'($urandom & $urandom & 12'hFFF);
                    step_v = tdb_pkg::CFG_DATA_W'($urandom_range(1, 100));
                    det_v = tdb_pkg::CFG_DATA_W'($urandom_range(0, 8 * step_v));
                    rel_v = tdb_pkg::CFG_DATA_W'($urandom_range(0, 8 * step_v));
                    cool_v = tdb_pkg::CFG_DATA_W'($urandom_range(0, 20 * step_v));
                end
            endcase
            apply_settings(mask_v, step_v, det_v, rel_v, cool_v);
            if (ph % 4 == 1) hold_off = 1'b1;
            if ($urandom_range(0, 1) == 1) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            run_phase(ph == 3 ? 40 : 135);
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        for (guard = 0; guard < 2000 && sb.expected_results.size() != 0; guard++)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        while (sb.expected_results.size() != 0) begin
            sb.flag_error("expected result word never arrived");
            void'(sb.expected_results.pop_front());
        end
        if (sb.errors == 0) begin
            $display("touch_debounce_trigger verification clean");
        end else begin
            $display("touch_debounce_trigger verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
